// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and the month-length lookup for the Gregorian date adder.
// No dependencies.
`default_nettype none

package gdad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned COUNT_W = 16;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_W-1:0] YEAR_CYCLE = 16'd400;
  localparam logic [8:0]        CENTURY_1  = 9'd100;
  localparam logic [8:0]        CENTURY_2  = 9'd200;
  localparam logic [8:0]        CENTURY_3  = 9'd300;
  localparam logic [8:0]        CYCLE_LAST = 9'd399;
  localparam logic [DAY_W-1:0]  FEB_LEAP   = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] days_to_add;
  } gdad_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               invalid_month;
  } gdad_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gdad_status_t;

  // Month must already be known to be 1..12.
  function automatic logic [DAY_W-1:0] gdad_month_len(input logic [MONTH_W-1:0] month,
                                                      input logic                leap);
    logic [3:0] idx;
    idx = month - MONTH_JAN;
    if (month == MONTH_FEB && leap) begin
      return FEB_LEAP;
    end
    return MONTH_LEN[idx];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gdad_seq.sv =====
// Sequencer and shared subtractor for the date adder: year mod 400 reduction,
// then a month-by-month walk. Depends on gdad_pkg.
`default_nettype none

module gdad_seq
  import gdad_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire gdad_in_t     item_i,
  input  wire logic         take_i,
  output gdad_out_t         res_o,
  output gdad_status_t      status_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [DAY_W-1:0]   day_q, day_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [COUNT_W:0]   left_q, left_d;
  logic [YEAR_W-1:0]  red_q, red_d;
  logic [2:0]         k_q, k_d;
  logic               bad_q, bad_d;

  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic signed [17:0] op_a, op_b, diff;

  // red_q holds year mod 400 once the reduction is done
  assign leap = (year_q[1:0] == 2'd0) && (red_q[8:0] != CENTURY_1) &&
                (red_q[8:0] != CENTURY_2) && (red_q[8:0] != CENTURY_3);
  assign dim  = gdad_month_len(month_q, leap);

  always_comb begin
    if (state_q == S_MOD) begin
      op_a = signed'({2'b00, red_q});
      op_b = signed'({2'b00, 16'(YEAR_CYCLE << k_q)});
    end else begin
      op_a = signed'({1'b0, left_q});
      op_b = signed'(18'(dim) + 18'd1 - 18'(day_q));
    end
    diff = op_a - op_b;
  end

  always_comb begin
    state_d = state_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    left_d  = left_q;
    red_d   = red_q;
    k_d     = k_q;
    bad_d   = bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          day_d   = item_i.start_day;
          month_d = item_i.start_month;
          year_d  = item_i.start_year;
          left_d  = {1'b0, item_i.days_to_add};
          red_d   = item_i.start_year;
          k_d     = 3'd7;
          bad_d   = (item_i.start_month < MONTH_JAN) || (item_i.start_month > MONTH_DEC);
          state_d = bad_d ? S_DONE : S_MOD;
        end
      end
      S_MOD: begin
        if (!diff[17]) begin
          red_d = diff[15:0];
        end
        k_d = k_q - 3'd1;
        if (k_q == 3'd0) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (left_q == '0) begin
          state_d = S_DONE;
        end else if (!diff[17]) begin
          left_d = diff[COUNT_W:0];
          day_d  = 5'd1;
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + 16'd1;
            red_d   = (year_q == 16'hFFFF || red_q[8:0] == CYCLE_LAST) ? '0 : red_q + 16'd1;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d  = day_q + left_q[DAY_W-1:0];
          left_d = '0;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    left_q  <= left_d;
    red_q   <= red_d;
    k_q     <= k_d;
    bad_q   <= bad_d;
  end

  assign res_o.result_day    = day_q;
  assign res_o.result_month  = month_q;
  assign res_o.result_year   = year_q;
  assign res_o.invalid_month = bad_q;
  assign status_o.busy       = (state_q != S_IDLE);
  assign status_o.done       = (state_q == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: input beat capture and output register.
// Depends on gdad_pkg and gdad_seq.
`default_nettype none

// One date at a time. After a beat is accepted the block reduces the year
// modulo 400 through its single subtractor. It then walks month by month,
// with one more step when the walk ends part-way through a month, and holds
// the result in its done state until the output register takes it.
// A start month outside 1..12 returns the date unchanged with invalid_month
// set, skipping the reduction and the walk. A finished result sits in the
// output register, so the next beat can be taken while it waits.
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire gdad_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output gdad_out_t      out_data_o
);

  gdad_status_t status;
  gdad_out_t    res;
  logic         in_acc;
  logic         take;
  logic         out_valid_q, out_valid_d;
  gdad_out_t    out_q;

  assign in_stall_o = status.busy;
  assign in_acc     = in_valid_i && !status.busy;
  assign take       = status.done && (!out_valid_q || !out_stall_i);

  gdad_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .item_i   (in_data_i),
    .take_i   (take),
    .res_o    (res),
    .status_o (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> status.busy)
    else $error("accepted beat did not start the sequencer");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q && !status.done)
    else $error("finished result not moved to output register");

  a_bad_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.invalid_month |->
      (out_q.result_month == 4'd0 || out_q.result_month > MONTH_DEC))
    else $error("invalid flag on a valid month");

  a_good_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.invalid_month |->
      (out_q.result_month != 4'd0 && out_q.result_month <= MONTH_DEC))
    else $error("result month out of range");

endmodule

`default_nettype wire

// ===== dv/gregorian_date_add_days_tb.sv =====
// Testbench for gregorian_date_add_days: a directed table of dates, then random dates,
// each result checked against its typed row or a month-by-month walk kept here.
// Depends on gdad_pkg and the gregorian_date_add_days RTL.
`default_nettype none

module gregorian_date_add_days_tb
  import gdad_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM     = 250;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_WALK    = 4096;

  localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam gdad_out_t NO_RESULT = '0;

  typedef struct packed {
    gdad_in_t  stim;
    logic      typed;
    gdad_out_t want;
  } date_row_t;

  localparam int N_ROWS = 22;

  // Typed rows: reset-style pass-through, invalid months, year wrap, day zero,
  // February in leap and non-leap centuries. The rest go through the predictor.
  localparam date_row_t DATE_ROWS [N_ROWS] = '{
    {5'd1,  4'd1,  16'd2024,  16'd0,     1'b1, 5'd1,  4'd1,  16'd2024,  1'b0},
    {5'd15, 4'd0,  16'd1999,  16'd100,   1'b1, 5'd15, 4'd0,  16'd1999,  1'b1},
    {5'd31, 4'd13, 16'd65535, 16'd65535, 1'b1, 5'd31, 4'd13, 16'd65535, 1'b1},
    {5'd0,  4'd14, 16'd0,     16'd1,     1'b1, 5'd0,  4'd14, 16'd0,     1'b1},
    {5'd7,  4'd15, 16'd12345, 16'd0,     1'b1, 5'd7,  4'd15, 16'd12345, 1'b1},
    {5'd31, 4'd12, 16'd65535, 16'd1,     1'b1, 5'd1,  4'd1,  16'd0,     1'b0},
    {5'd0,  4'd3,  16'd2023,  16'd5,     1'b1, 5'd5,  4'd3,  16'd2023,  1'b0},
    {5'd0,  4'd3,  16'd2023,  16'd0,     1'b1, 5'd0,  4'd3,  16'd2023,  1'b0},
    {5'd31, 4'd12, 16'd65535, 16'd0,     1'b1, 5'd31, 4'd12, 16'd65535, 1'b0},
    {5'd28, 4'd2,  16'd2024,  16'd1,     1'b1, 5'd29, 4'd2,  16'd2024,  1'b0},
    {5'd28, 4'd2,  16'd1900,  16'd1,     1'b1, 5'd1,  4'd3,  16'd1900,  1'b0},
    {5'd28, 4'd2,  16'd2000,  16'd1,     1'b1, 5'd29, 4'd2,  16'd2000,  1'b0},
    {5'd28, 4'd2,  16'd0,     16'd1,     1'b1, 5'd29, 4'd2,  16'd0,     1'b0},
    {5'd1,  4'd1,  16'd2023,  16'd365,   1'b1, 5'd1,  4'd1,  16'd2024,  1'b0},
    {5'd30, 4'd2,  16'd2023,  16'd1,     1'b0, NO_RESULT},
    {5'd31, 4'd2,  16'd2024,  16'd3,     1'b0, NO_RESULT},
    {5'd31, 4'd4,  16'd2023,  16'd1,     1'b0, NO_RESULT},
    {5'd31, 4'd11, 16'd9999,  16'd31,    1'b0, NO_RESULT},
    {5'd29, 4'd2,  16'd2100,  16'd400,   1'b0, NO_RESULT},
    {5'd31, 4'd12, 16'd65535, 16'd65535, 1'b0, NO_RESULT},
    {5'd1,  4'd1,  16'd0,     16'd65535, 1'b0, NO_RESULT},
    {5'd0,  4'd1,  16'd65500, 16'd65535, 1'b0, NO_RESULT}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  gdad_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  gdad_out_t out_data_o;

  gdad_out_t later_dates [$];
  int        beats_sent   = 0;
  int        results_seen = 0;
  int        fail_count   = 0;
  int        invalid_sent = 0;
  int        long_walks   = 0;
  int        cycle_count  = 0;
  logic [9:0] stall_tick  = '0;

  gregorian_date_add_days u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Walk forward one month at a time; a past-the-end first day can make room negative.
  function automatic gdad_out_t calc_later_date(input gdad_in_t d);
    int          day;
    int          month;
    int          left;
    int          room;
    int          mlen;
    int unsigned year;
    gdad_out_t   r;
    day   = d.start_day;
    month = d.start_month;
    year  = d.start_year;
    left  = d.days_to_add;
    r.invalid_month = (month < 1 || month > 12);
    if (!r.invalid_month) begin
      while (left > 0) begin
        if (month == MONTH_FEB) begin
          mlen = ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0) ? 29 : 28;
        end else begin
          mlen = DAYS_PER_MONTH[month-1];
        end
        room = mlen - day;
        if (left > room) begin
          left  = left - (room + 1);
          day   = 1;
          month = month + 1;
          if (month == 13) begin
            month = 1;
            year  = (year + 1) & 16'hFFFF;
          end
        end else begin
          day  = day + left;
          left = 0;
        end
      end
    end
    r.result_day   = day[DAY_W-1:0];
    r.result_month = month[MONTH_W-1:0];
    r.result_year  = year[YEAR_W-1:0];
    return r;
  endfunction

  function automatic gdad_in_t make_random_date(input int idx);
    gdad_in_t d;
    int       pick;
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(0, 3);
      d.start_month = (pick == 0) ? 4'd0 : 4'(12 + pick);
    end else begin
      d.start_month = 4'($urandom_range(1, 12));
    end
    if ($urandom_range(0, 7) == 0) begin
      d.start_day = 5'($urandom_range(0, 31));
    end else begin
      d.start_day = 5'($urandom_range(1, 28));
    end
    case ($urandom_range(0, 3))
      0:       d.start_year = 16'($urandom_range(0, 65535));
      1:       d.start_year = 16'(65535 - $urandom_range(0, 5));
      2:       d.start_year = 16'($urandom_range(0, 655) * 100);
      default: d.start_year = 16'($urandom_range(1900, 2500));
    endcase
    if (idx % 10 == 0) begin
      d.days_to_add = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    end else if ($urandom_range(0, 3) == 0) begin
      d.days_to_add = 16'($urandom_range(0, 40));
    end else begin
      d.days_to_add = 16'($urandom_range(0, 800));
    end
    return d;
  endfunction

  // Hold the beat until taken; the caller decides whether valid drops afterwards.
  task automatic drive_date(input gdad_in_t d, input logic typed, input gdad_out_t want);
    gdad_out_t exp_date;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    exp_date = typed ? want : calc_later_date(d);
    later_dates.push_back(exp_date);
    beats_sent++;
    if (exp_date.invalid_month) invalid_sent++;
    if (d.days_to_add >= LONG_WALK) long_walks++;
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_dates();
    in_valid_i <= 1'b0;
    while (later_dates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int idx;
    int burst;
    int gap;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      drive_date(DATE_ROWS[i].stim, DATE_ROWS[i].typed, DATE_ROWS[i].want);
      gap = $urandom_range(0, 2);
      if (gap != 0) idle_sender(gap);
    end
    wait_all_dates();

    idx = 0;
    while (idx < N_RANDOM) begin
      burst = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 8);
      for (int k = 0; k < burst && idx < N_RANDOM; k++) begin
        drive_date(make_random_date(idx), 1'b0, NO_RESULT);
        idx++;
        if (idx == N_RANDOM / 2) wait_all_dates();
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) idle_sender(gap);
    end

    wait_all_dates();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d date beats sent (%0d with an invalid month, %0d long walks), %0d results checked",
             beats_sent, invalid_sent, long_walks, results_seen);
    if (fail_count == 0) begin
      $display("gregorian_date_add_days: match");
    end else begin
      $display("gregorian_date_add_days: mismatch");
    end
    $finish;
  end

  // Receiver stall: off, light random, heavy random, then a fixed on/off rhythm.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_tick[2];
    endcase
  end

  always @(posedge clk_i) begin
    gdad_out_t exp_date;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("gregorian_date_add_days: mismatch");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (later_dates.size() == 0) begin
        $error("unexpected result beat: %0d/%0d/%0d invalid %0b", out_data_o.result_day,
               out_data_o.result_month, out_data_o.result_year, out_data_o.invalid_month);
        fail_count <= fail_count + 1;
      end else begin
        exp_date = later_dates.pop_front();
        if (out_data_o !== exp_date) begin
          fail_count <= fail_count + 1;
          if (out_data_o.result_day !== exp_date.result_day)
            $error("result_day: expected %0d, got %0d",
                   exp_date.result_day, out_data_o.result_day);
          if (out_data_o.result_month !== exp_date.result_month)
            $error("result_month: expected %0d, got %0d",
                   exp_date.result_month, out_data_o.result_month);
          if (out_data_o.result_year !== exp_date.result_year)
            $error("result_year: expected %0d, got %0d",
                   exp_date.result_year, out_data_o.result_year);
          if (out_data_o.invalid_month !== exp_date.invalid_month)
            $error("invalid_month: expected %0b, got %0b",
                   exp_date.invalid_month, out_data_o.invalid_month);
        end
      end
    end
  end

endmodule

`default_nettype wire
